@@ sv/bilinear_image_resampler_assert.svh @@
// Assertion macros for the resampler top module. Each macro samples on
// clk_i and is disabled while rst_ni is low.
`ifndef BILINEAR_IMAGE_RESAMPLER_ASSERT_SVH
`define BILINEAR_IMAGE_RESAMPLER_ASSERT_SVH

// The condition holds at every clock edge.
`define BIR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define BIR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bir_pkg.sv @@
`timescale 1ns / 1ps

package bir_pkg;

  localparam int unsigned PIX_W     = 16;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned UNIT_W    = FRAC_W + 1;
  localparam int unsigned WGT_W     = UNIT_W + 1;
  localparam int unsigned STEP_W    = 25;
  localparam int unsigned DIM_W     = 9;
  localparam int unsigned DIMX_W    = 13;
  localparam int unsigned SRC_W     = 8;
  localparam int unsigned DST_W     = 12;
  localparam int unsigned BIAS_W    = 39;
  localparam int unsigned POS_W     = BIAS_W - UNIT_W;
  localparam int unsigned COLP_W    = UNIT_W + PIX_W;
  localparam int unsigned SUM_W     = 2 * UNIT_W + PIX_W;
  localparam int unsigned NUM_BANKS = 4;

  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam int unsigned OFIFO_DEPTH = 8;
  localparam int unsigned OF_PTR_W    = $clog2(OFIFO_DEPTH);
  localparam int unsigned OF_CNT_W    = $clog2(OFIFO_DEPTH + 1);

  localparam logic [DIM_W-1:0]  RST_DIM  = DIM_W'(256);
  localparam logic [STEP_W-1:0] RST_STEP = STEP_W'(65536);
  localparam logic [WGT_W-1:0]  UNIT_WGT = WGT_W'(1) << UNIT_W;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_SRC_ROWS = 2'd0,
    REG_SRC_COLS = 2'd1,
    REG_ROW_STEP = 2'd2,
    REG_COL_STEP = 2'd3
  } cfg_reg_e;

  // Per-query neighbor data, neighbor k = {row offset, column offset}.
  typedef struct packed {
    logic              hr0;
    logic              hc0;
    logic [3:0]        nv;
    logic [UNIT_W-1:0] wr;
    logic [UNIT_W-1:0] wc;
    logic [DST_W-1:0]  row;
    logic [DST_W-1:0]  col;
  } nb_pay_t;

  typedef struct packed {
    logic    vld;
    nb_pay_t pay;
  } nb_t;

  typedef struct packed {
    logic [DST_W-1:0] col;
    logic [DST_W-1:0] row;
    logic [PIX_W-1:0] pixel;
  } res_t;

endpackage

@@ sv/bir_bank_ram.sv @@
`timescale 1ns / 1ps

module bir_bank_ram #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = 14
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [bir_pkg::PIX_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [bir_pkg::PIX_W-1:0] rdata_o
);
  import bir_pkg::*;

  logic [PIX_W-1:0] mem_q [DEPTH];
  logic [PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/bir_locate.sv @@
`timescale 1ns / 1ps

module bir_locate #(
  parameter int unsigned MAX_ROWS = 256,
  parameter int unsigned MAX_COLS = 256,
  localparam int unsigned HALF_ROWS  = (MAX_ROWS + 1) / 2,
  localparam int unsigned HALF_COLS  = (MAX_COLS + 1) / 2,
  localparam int unsigned BANK_DEPTH = HALF_ROWS * HALF_COLS,
  localparam int unsigned BA_W = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_vld_i,
  input  bir_pkg::cmd_e               cmd_i,
  input  logic [bir_pkg::SRC_W-1:0]   src_row_i,
  input  logic [bir_pkg::SRC_W-1:0]   src_col_i,
  input  logic [bir_pkg::PIX_W-1:0]   pixel_i,
  input  logic [bir_pkg::DST_W-1:0]   dst_row_i,
  input  logic [bir_pkg::DST_W-1:0]   dst_col_i,
  input  logic [bir_pkg::STEP_W-1:0]  row_step_i,
  input  logic [bir_pkg::STEP_W-1:0]  col_step_i,
  input  logic [bir_pkg::DIMX_W-1:0]  n_rows_i,
  input  logic [bir_pkg::DIMX_W-1:0]  n_cols_i,
  output logic                        rd_en_o,
  output logic [3:0][BA_W-1:0]        rd_addr_o,
  output logic [3:0]                  wr_en_o,
  output logic [BA_W-1:0]             wr_addr_o,
  output logic [bir_pkg::PIX_W-1:0]   wr_data_o,
  output bir_pkg::nb_t                nb_o
);
  import bir_pkg::*;

  localparam int unsigned HRW  = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
  localparam int unsigned HCW  = (HALF_COLS > 1) ? $clog2(HALF_COLS) : 1;
  localparam int unsigned AC_W = HRW + HCW + 1;

  typedef struct packed {
    cmd_e              cmd;
    logic [SRC_W-1:0]  src_row;
    logic [SRC_W-1:0]  src_col;
    logic [PIX_W-1:0]  pixel;
    logic [DST_W-1:0]  dst_row;
    logic [DST_W-1:0]  dst_col;
    logic [BIAS_W-1:0] bias_r;
    logic [BIAS_W-1:0] bias_c;
  } stage_a_t;

  function automatic logic [BA_W-1:0] bank_addr(input logic [HRW-1:0] rh,
                                                input logic [HCW-1:0] ch);
    return BA_W'(AC_W'(rh) * AC_W'(HALF_COLS) + AC_W'(ch));
  endfunction

  logic     a_vld_q;
  stage_a_t a_q, a_d;

  logic [POS_W-1:0] hr, hc, hr_half, hc_half;
  logic [HRW-1:0]   rh_even, rh_odd, rh_wr;
  logic [HCW-1:0]   ch_even, ch_odd, ch_wr;
  logic             rv0, rv1, cv0, cv1, wr_in_range;
  logic             nb_vld_q;
  nb_pay_t          nb_pay_q, nb_pay_d;

  // Position times two plus one unit: (2*idx+1)*step + 2^FRAC_W.
  always_comb begin
    a_d.cmd     = cmd_i;
    a_d.src_row = src_row_i;
    a_d.src_col = src_col_i;
    a_d.pixel   = pixel_i;
    a_d.dst_row = dst_row_i;
    a_d.dst_col = dst_col_i;
    a_d.bias_r  = BIAS_W'({dst_row_i, 1'b1}) * BIAS_W'(row_step_i)
                  + (BIAS_W'(1) << FRAC_W);
    a_d.bias_c  = BIAS_W'({dst_col_i, 1'b1}) * BIAS_W'(col_step_i)
                  + (BIAS_W'(1) << FRAC_W);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_i) begin
      a_q <= a_d;
    end
  end

  // hr is the upper neighbor row; the lower one is hr-1. Of the two rows,
  // the even one sits at half-index hr>>1 in its bank, and the odd one at
  // hr>>1 or one less.
  always_comb begin
    hr      = a_q.bias_r[BIAS_W-1:UNIT_W];
    hc      = a_q.bias_c[BIAS_W-1:UNIT_W];
    hr_half = hr >> 1;
    hc_half = hc >> 1;
    rh_even = HRW'(hr_half);
    rh_odd  = HRW'(hr[0] ? hr_half : hr_half - POS_W'(1));
    ch_even = HCW'(hc_half);
    ch_odd  = HCW'(hc[0] ? hc_half : hc_half - POS_W'(1));

    rv0 = (hr != '0) && (hr <= POS_W'(n_rows_i));
    rv1 = hr < POS_W'(n_rows_i);
    cv0 = (hc != '0) && (hc <= POS_W'(n_cols_i));
    cv1 = hc < POS_W'(n_cols_i);

    rd_en_o      = a_vld_q && (a_q.cmd == CMD_QUERY);
    rd_addr_o[0] = bank_addr(rh_even, ch_even);
    rd_addr_o[1] = bank_addr(rh_even, ch_odd);
    rd_addr_o[2] = bank_addr(rh_odd, ch_even);
    rd_addr_o[3] = bank_addr(rh_odd, ch_odd);

    rh_wr       = HRW'(a_q.src_row >> 1);
    ch_wr       = HCW'(a_q.src_col >> 1);
    wr_in_range = (DIMX_W'(a_q.src_row) < DIMX_W'(MAX_ROWS))
                  && (DIMX_W'(a_q.src_col) < DIMX_W'(MAX_COLS));
    wr_addr_o   = bank_addr(rh_wr, ch_wr);
    wr_data_o   = a_q.pixel;
    wr_en_o     = (a_vld_q && (a_q.cmd == CMD_LOAD) && wr_in_range)
                  ? (4'b0001 << {a_q.src_row[0], a_q.src_col[0]}) : 4'b0000;

    nb_pay_d.hr0 = hr[0];
    nb_pay_d.hc0 = hc[0];
    nb_pay_d.nv  = {rv1 & cv1, rv1 & cv0, rv0 & cv1, rv0 & cv0};
    nb_pay_d.wr  = a_q.bias_r[UNIT_W-1:0];
    nb_pay_d.wc  = a_q.bias_c[UNIT_W-1:0];
    nb_pay_d.row = a_q.dst_row;
    nb_pay_d.col = a_q.dst_col;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_vld_q <= 1'b0;
    end else begin
      nb_vld_q <= rd_en_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_o) begin
      nb_pay_q <= nb_pay_d;
    end
  end

  always_comb begin
    nb_o.vld = nb_vld_q;
    nb_o.pay = nb_pay_q;
  end

endmodule

@@ sv/bir_blend.sv @@
`timescale 1ns / 1ps

module bir_blend (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bir_pkg::nb_t                     nb_i,
  input  logic [3:0][bir_pkg::PIX_W-1:0]   rdata_i,
  output logic                             res_vld_o,
  output bir_pkg::res_t                    res_o
);
  import bir_pkg::*;

  typedef struct packed {
    logic [COLP_W-1:0] t0;
    logic [COLP_W-1:0] t1;
    logic [COLP_W-1:0] b0;
    logic [COLP_W-1:0] b1;
    logic [UNIT_W-1:0] wr;
    logic [DST_W-1:0]  row;
    logic [DST_W-1:0]  col;
  } stage_c_t;

  typedef struct packed {
    logic [COLP_W-1:0] top;
    logic [COLP_W-1:0] bot;
    logic [UNIT_W-1:0] wr;
    logic [DST_W-1:0]  row;
    logic [DST_W-1:0]  col;
  } stage_d_t;

  typedef struct packed {
    logic [SUM_W-1:0] s0;
    logic [SUM_W-1:0] s1;
    logic [DST_W-1:0] row;
    logic [DST_W-1:0] col;
  } stage_e_t;

  logic [3:0][PIX_W-1:0] pix;
  logic [WGT_W-1:0]      wc_hi, wc_lo, wr_hi, wr_lo;
  logic [SUM_W-1:0]      rnd;
  logic                  c_vld_q, d_vld_q, e_vld_q;
  stage_c_t              c_q, c_d;
  stage_d_t              d_q, d_d;
  stage_e_t              e_q, e_d;

  // Neighbor k = {row offset, column offset}; the lower row has parity ~hr0.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pix[k] = nb_i.pay.nv[k]
               ? rdata_i[2'(k) ^ {~nb_i.pay.hr0, ~nb_i.pay.hc0}] : '0;
    end
    wc_hi   = WGT_W'(nb_i.pay.wc);
    wc_lo   = UNIT_WGT - wc_hi;
    c_d.t0  = COLP_W'(wc_lo) * COLP_W'(pix[0]);
    c_d.t1  = COLP_W'(wc_hi) * COLP_W'(pix[1]);
    c_d.b0  = COLP_W'(wc_lo) * COLP_W'(pix[2]);
    c_d.b1  = COLP_W'(wc_hi) * COLP_W'(pix[3]);
    c_d.wr  = nb_i.pay.wr;
    c_d.row = nb_i.pay.row;
    c_d.col = nb_i.pay.col;

    d_d.top = c_q.t0 + c_q.t1;
    d_d.bot = c_q.b0 + c_q.b1;
    d_d.wr  = c_q.wr;
    d_d.row = c_q.row;
    d_d.col = c_q.col;

    wr_hi   = WGT_W'(d_q.wr);
    wr_lo   = UNIT_WGT - wr_hi;
    e_d.s0  = SUM_W'(wr_lo) * SUM_W'(d_q.top);
    e_d.s1  = SUM_W'(wr_hi) * SUM_W'(d_q.bot);
    e_d.row = d_q.row;
    e_d.col = d_q.col;

    // Add half an output LSB and keep the top bits: halves round up.
    rnd         = e_q.s0 + e_q.s1 + (SUM_W'(1) << (2 * UNIT_W - 1));
    res_o.pixel = rnd[SUM_W-1 -: PIX_W];
    res_o.row   = e_q.row;
    res_o.col   = e_q.col;
    res_vld_o   = e_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else begin
      c_vld_q <= nb_i.vld;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nb_i.vld) begin
      c_q <= c_d;
    end
    if (c_vld_q) begin
      d_q <= d_d;
    end
    if (d_vld_q) begin
      e_q <= e_d;
    end
  end

endmodule

@@ sv/bilinear_image_resampler.sv @@
`timescale 1ns / 1ps
// Bilinear image resampler with the pixel-center convention.
// The slave stream carries load beats (tuser 0) that write one source pixel
// and query beats (tuser 1) that ask for one destination pixel. Each query
// gives exactly one master-stream beat with the interpolated pixel and its
// destination row and column; loads give none. Results leave in query order.
// The source image lives in four banks split by row and column parity, so
// the four neighbors of a query come out of one parallel read of the banks.
// That makes the block take one beat per cycle, loads and queries alike,
// whenever slave tready is high. A query passes through locate, bank read,
// column products, column sums, row products, then rounding into the
// output queue before its result shows on the master side.
// A stalled receiver fills an eight-entry output queue; slave tready drops
// once eight queries are accepted but not yet delivered, so no result is
// lost. Loads are not held back by a stalled receiver except through that
// same limit. Reset empties the pipeline and queue and sets the registers to
// a 256 x 256 source with unit steps; pixel contents are not cleared, and
// every pixel a query uses must be loaded first. The user must make
// configuration writes only while no query is in flight (not enforced).
`include "bilinear_image_resampler_assert.svh"

module bilinear_image_resampler #(
  parameter int unsigned MAX_ROWS = 256,
  parameter int unsigned MAX_COLS = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Slave stream. tdata: src_row[7:0], src_col[15:8], pixel_in[31:16],
  // dst_row[43:32], dst_col[55:44]. tuser: cmd[0].
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bir_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic [0:0]                        s_axis_tuser,
  // Master stream. tdata: pixel_out[15:0], out_row[27:16], out_col[39:28].
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bir_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // Configuration writes.
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [bir_pkg::STEP_W-1:0]        cfg_data_i
);
  import bir_pkg::*;

  localparam int unsigned HALF_ROWS  = (MAX_ROWS + 1) / 2;
  localparam int unsigned HALF_COLS  = (MAX_COLS + 1) / 2;
  localparam int unsigned BANK_DEPTH = HALF_ROWS * HALF_COLS;
  localparam int unsigned BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // Configuration registers.
  logic [DIM_W-1:0]  src_rows_q, src_cols_q;
  logic [STEP_W-1:0] row_step_q, col_step_q;
  logic [DIMX_W-1:0] n_rows, n_cols;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_rows_q <= RST_DIM;
      src_cols_q <= RST_DIM;
      row_step_q <= RST_STEP;
      col_step_q <= RST_STEP;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SRC_ROWS: src_rows_q <= cfg_data_i[DIM_W-1:0];
        REG_SRC_COLS: src_cols_q <= cfg_data_i[DIM_W-1:0];
        REG_ROW_STEP: row_step_q <= cfg_data_i;
        REG_COL_STEP: col_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // An image larger than the store acts as the store's size.
  assign n_rows = (DIMX_W'(src_rows_q) > DIMX_W'(MAX_ROWS))
                  ? DIMX_W'(MAX_ROWS) : DIMX_W'(src_rows_q);
  assign n_cols = (DIMX_W'(src_cols_q) > DIMX_W'(MAX_COLS))
                  ? DIMX_W'(MAX_COLS) : DIMX_W'(src_cols_q);

  // Beat handshakes and the count of queries not yet delivered.
  logic                s_acc, m_pop, s_query;
  cmd_e                s_cmd;
  logic [OF_CNT_W-1:0] used_q, used_d;

  assign s_cmd         = cmd_e'(s_axis_tuser[0]);
  assign s_axis_tready = used_q < OF_CNT_W'(OFIFO_DEPTH);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign s_query       = s_acc && (s_cmd == CMD_QUERY);
  assign m_pop         = m_axis_tvalid && m_axis_tready;

  always_comb begin
    used_d = used_q;
    if (s_query && !m_pop) begin
      used_d = used_q + OF_CNT_W'(1);
    end else if (!s_query && m_pop) begin
      used_d = used_q - OF_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  // Neighbor location and bank addressing.
  logic                  rd_en;
  logic [3:0][BA_W-1:0]  rd_addr;
  logic [3:0]            wr_en;
  logic [BA_W-1:0]       wr_addr;
  logic [PIX_W-1:0]      wr_data;
  logic [3:0][PIX_W-1:0] rdata;
  nb_t                   nb;

  bir_locate #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_locate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (s_acc),
    .cmd_i      (s_cmd),
    .src_row_i  (s_axis_tdata[7:0]),
    .src_col_i  (s_axis_tdata[15:8]),
    .pixel_i    (s_axis_tdata[31:16]),
    .dst_row_i  (s_axis_tdata[43:32]),
    .dst_col_i  (s_axis_tdata[55:44]),
    .row_step_i (row_step_q),
    .col_step_i (col_step_q),
    .n_rows_i   (n_rows),
    .n_cols_i   (n_cols),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .nb_o       (nb)
  );

  // Bank {row parity, column parity} holds the pixels of that parity pair.
  // A load and a later query reach the banks in accept order, so a query
  // always sees every load accepted before it.
  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    bir_bank_ram #(
      .DEPTH (BANK_DEPTH),
      .AW    (BA_W)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_en[g]),
      .waddr_i (wr_addr),
      .wdata_i (wr_data),
      .re_i    (rd_en),
      .raddr_i (rd_addr[g]),
      .rdata_o (rdata[g])
    );
  end

  // Weighted blend: columns first, then rows, then rounding.
  logic res_vld;
  res_t res;

  bir_blend u_blend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .nb_i      (nb),
    .rdata_i   (rdata),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // Output queue. It is deep enough for every query in flight, so the
  // pipeline never has to stop.
  res_t                fifo_q [OFIFO_DEPTH];
  logic [OF_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OF_CNT_W-1:0] fifo_cnt_q;

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (res_vld) begin
        wr_ptr_q <= wr_ptr_q + OF_PTR_W'(1);
      end
      if (m_pop) begin
        rd_ptr_q <= rd_ptr_q + OF_PTR_W'(1);
      end
      if (res_vld && !m_pop) begin
        fifo_cnt_q <= fifo_cnt_q + OF_CNT_W'(1);
      end else if (!res_vld && m_pop) begin
        fifo_cnt_q <= fifo_cnt_q - OF_CNT_W'(1);
      end
    end
  end

  assign m_axis_tvalid = fifo_cnt_q != '0;
  assign m_axis_tdata  = fifo_q[rd_ptr_q];

  // Every queued result belongs to a counted query.
  `BIR_ASSERT_ALWAYS(a_used_covers_queue, used_q >= fifo_cnt_q, "queue holds uncounted results")
  // The pipeline never pushes into a full queue.
  `BIR_ASSERT_IMP(a_no_overflow, res_vld, (fifo_cnt_q != OF_CNT_W'(OFIFO_DEPTH)) || m_pop, "output queue overflow")
  // A query accepted without a delivery raises the in-flight count.
  `BIR_ASSERT_NEXT(a_query_counted, s_query && !m_pop, used_q == $past(used_q) + OF_CNT_W'(1), "query not counted")
  // A result on the master side always has an outstanding query behind it.
  `BIR_ASSERT_IMP(a_result_has_query, m_axis_tvalid, used_q != '0, "result without query")

endmodule

@@ tb/bir_stream_checker.sv @@
`timescale 1ns / 1ps

// Watches both streams and the register port of the resampler. It predicts
// every query result and compares it with the next master beat.
module bir_stream_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [bir_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [0:0]                      s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [bir_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [bir_pkg::STEP_W-1:0]      cfg_data_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o,
  output int unsigned                     checked_o
);
  import bir_pkg::*;

  localparam longint STORE_ROWS = 256;
  localparam longint STORE_COLS = 256;
  localparam int unsigned MAX_REPORTS = 40;

  logic [PIX_W-1:0]  src_image [0:65535];
  logic [DIM_W-1:0]  rows_q, cols_q;
  logic [STEP_W-1:0] row_step_q, col_step_q;
  res_t              expected_pixels [$];
  int unsigned       fails = 0;
  int unsigned       checked = 0;

  initial begin
    for (int i = 0; i < 65536; i++) src_image[i] = '0;
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  function automatic longint unsigned source_pixel(input longint r, input longint c);
    longint nr, nc;
    nr = (rows_q > STORE_ROWS) ? STORE_ROWS : longint'(rows_q);
    nc = (cols_q > STORE_COLS) ? STORE_COLS : longint'(cols_q);
    if (r < 0 || c < 0 || r >= nr || c >= nc) return 0;
    return longint'(src_image[{r[7:0], c[7:0]}]);
  endfunction

  // Lower neighbor and upper-neighbor weight in units of 2^-17.
  function automatic void locate_axis(input logic [DST_W-1:0] idx,
                                      input logic [STEP_W-1:0] step,
                                      output longint lo,
                                      output longint unsigned wgt);
    longint unsigned biased;
    biased = (64'(idx) * 2 + 1) * 64'(step) + (64'd1 << FRAC_W);
    lo     = longint'(biased >> UNIT_W) - 1;
    wgt    = biased & ((64'd1 << UNIT_W) - 1);
  endfunction

  function automatic logic [PIX_W-1:0] interpolate_pixel(input logic [DST_W-1:0] dr,
                                                         input logic [DST_W-1:0] dc);
    longint r0, c0;
    longint unsigned wr, wc, unit, upper, lower, sum;
    unit = 64'd1 << UNIT_W;
    locate_axis(dr, row_step_q, r0, wr);
    locate_axis(dc, col_step_q, c0, wc);
    upper = (unit - wc) * source_pixel(r0, c0) + wc * source_pixel(r0, c0 + 1);
    lower = (unit - wc) * source_pixel(r0 + 1, c0) + wc * source_pixel(r0 + 1, c0 + 1);
    sum   = (unit - wr) * upper + wr * lower;
    return PIX_W'((sum + (64'd1 << (2 * UNIT_W - 1))) >> (2 * UNIT_W));
  endfunction

  task automatic note_mismatch(input string field, input res_t want,
                               input int unsigned exp_val, input int unsigned act_val);
    if (fails < MAX_REPORTS)
      $display("%0t ns: %s mismatch for dst (%0d,%0d): expected %0d, got %0d",
               $time, field, want.row, want.col, exp_val, act_val);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    res_t got, want;
    if (!rst_ni) begin
      rows_q     = RST_DIM;
      cols_q     = RST_DIM;
      row_step_q = RST_STEP;
      col_step_q = RST_STEP;
      expected_pixels.delete();
      pending_o <= 0;
    end else begin
      // Results first: a query taken at this edge cannot leave at the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata);
        if (expected_pixels.size() == 0) begin
          if (fails < MAX_REPORTS)
            $display("%0t ns: unexpected result: expected none, got pixel %0d dst (%0d,%0d)",
                     $time, got.pixel, got.row, got.col);
          fails++;
        end else begin
          want = expected_pixels.pop_front();
          checked++;
          if (got.pixel !== want.pixel) note_mismatch("pixel_out", want, want.pixel, got.pixel);
          if (got.row !== want.row) note_mismatch("out_row", want, want.row, got.row);
          if (got.col !== want.col) note_mismatch("out_col", want, want.col, got.col);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (cmd_e'(s_axis_tuser[0]) == CMD_LOAD) begin
          src_image[{s_axis_tdata[7:0], s_axis_tdata[15:8]}] = s_axis_tdata[31:16];
        end else begin
          want.row   = s_axis_tdata[43:32];
          want.col   = s_axis_tdata[55:44];
          want.pixel = interpolate_pixel(want.row, want.col);
          expected_pixels.push_back(want);
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_SRC_ROWS: rows_q = cfg_data_i[DIM_W-1:0];
          REG_SRC_COLS: cols_q = cfg_data_i[DIM_W-1:0];
          REG_ROW_STEP: row_step_q = cfg_data_i;
          REG_COL_STEP: col_step_q = cfg_data_i;
          default: ;
        endcase
      end
      pending_o    <= expected_pixels.size();
      fail_count_o <= fails;
      checked_o    <= checked;
    end
  end

endmodule

@@ tb/tb_bilinear_image_resampler.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the bilinear resampler. The checker instance
// beside the block predicts and compares every result; this module only
// drives beats, register writes and ready, and reports the outcome.
module tb_bilinear_image_resampler;
  import bir_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 50_000;
  // Margin beyond the pipeline depth, so loads still in the pipe settle.
  localparam int unsigned SETTLE_CYCLES   = 12;
  localparam int unsigned RX_HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 40;
  // Side of the square block at the image origin that is loaded up front.
  localparam int unsigned PRELOAD_DIM     = 12;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i = 1'b0;
  logic [1:0]             cfg_idx_i = '0;
  logic [STEP_W-1:0]      cfg_data_i = '0;

  int unsigned fail_count, pending, checked;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_req = 0;
  int unsigned rx_hold_seen = 0;
  int unsigned rx_hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned n_loads = 0;
  int unsigned n_queries = 0;
  int unsigned n_settings = 1;

  bilinear_image_resampler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  bir_stream_checker stream_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  always #5 clk_i = ~clk_i;

  // Receiver. A hold-off request from the stimulus process is noticed here
  // and counted out in this process, so the sender keeps offering beats
  // while ready stays low and the output queue of the block fills up.
  always @(posedge clk_i) begin
    if (rx_hold_left != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left  <= rx_hold_left - 1;
    end else if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen  <= rx_hold_req;
      rx_hold_left  <= RX_HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog for a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offers one beat and returns at the edge that accepts it. Valid is only
  // lowered for an idle cycle, so it never drops and rises in one step.
  task automatic send_beat(input cmd_e cmd, input logic [IN_TDATA_W-1:0] beat);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // The fields a beat does not use carry random bits.
  task automatic load_pixel(input logic [SRC_W-1:0] row, input logic [SRC_W-1:0] col,
                            input logic [PIX_W-1:0] value);
    send_beat(CMD_LOAD, {DST_W'($urandom), DST_W'($urandom), value, col, row});
    n_loads++;
  endtask

  task automatic query_pixel(input logic [DST_W-1:0] row, input logic [DST_W-1:0] col);
    send_beat(CMD_QUERY, {col, row, PIX_W'($urandom), SRC_W'($urandom), SRC_W'($urandom)});
    n_queries++;
  endtask

  // Stops offering, waits for the next edge so the checker has seen the last
  // beat, then waits for every result and an optional settling stretch.
  task automatic drain_and_settle(input int unsigned settle);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols,
                              input logic [STEP_W-1:0] rstep, input logic [STEP_W-1:0] cstep);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SRC_ROWS;
    cfg_data_i <= STEP_W'(rows);
    @(posedge clk_i);
    cfg_idx_i  <= REG_SRC_COLS;
    cfg_data_i <= STEP_W'(cols);
    @(posedge clk_i);
    cfg_idx_i  <= REG_ROW_STEP;
    cfg_data_i <= rstep;
    @(posedge clk_i);
    cfg_idx_i  <= REG_COL_STEP;
    cfg_data_i <= cstep;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    n_settings++;
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
      end
      IDLE_SEND: begin
        tx_idle_pct = 48;
        rx_stall_pct <= 0;
      end
      IDLE_RECV: begin
        tx_idle_pct = 0;
        rx_stall_pct <= 48;
      end
      default: begin
        tx_idle_pct = 15;
        rx_stall_pct <= 15;
      end
    endcase
  endtask

  // Image sizes inside the preloaded block: empty, single line, the whole
  // block and sizes in between.
  function automatic logic [DIM_W-1:0] random_dim();
    case ($urandom_range(9))
      0:       return '0;
      1:       return DIM_W'(1);
      2:       return DIM_W'(PRELOAD_DIM);
      default: return DIM_W'($urandom_range(2, PRELOAD_DIM - 1));
    endcase
  endfunction

  // Mostly a true src/dst ratio, sometimes an extreme or an arbitrary step.
  function automatic logic [STEP_W-1:0] random_step(input logic [DIM_W-1:0] dim);
    longint unsigned eff;
    eff = (dim == 0) ? 1 : ((dim > 256) ? 256 : dim);
    case ($urandom_range(9))
      0:       return '0;
      1:       return STEP_W'(1);
      2:       return {STEP_W{1'b1}};
      3:       return STEP_W'(25'h1000000);
      4:       return STEP_W'($urandom);
      default: return STEP_W'((eff * 65536) / $urandom_range(1, 64));
    endcase
  endfunction

  // Destination indices that still land on the source image, plus one.
  function automatic int unsigned query_span(input logic [DIM_W-1:0] dim,
                                             input logic [STEP_W-1:0] step);
    longint unsigned eff, span;
    eff = (dim > 256) ? 256 : dim;
    if (step == 0) return 4095;
    span = (eff * 65536) / step + 1;
    return (span > 4095) ? 4095 : int'(span);
  endfunction

  initial begin
    logic [DIM_W-1:0]  rows, cols;
    logic [STEP_W-1:0] rstep, cstep;
    int unsigned       row_span, col_span, row_top, col_top;

    set_idling(IDLE_NONE);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A query may only touch loaded pixels. The random phases keep their
    // images inside this block, and the directed queries touch only pixels
    // of the block or pixels loaded just below.
    for (int r = 0; r < PRELOAD_DIM; r++)
      for (int c = 0; c < PRELOAD_DIM; c++)
        load_pixel(SRC_W'(r), SRC_W'(c), PIX_W'($urandom));

    // Directed part, first with the registers as reset left them: unit
    // steps land exactly on pixels, so the corners read back as loaded.
    load_pixel(8'd0, 8'd0, 16'hFFFF);
    load_pixel(8'd0, 8'd1, 16'hFFFF);
    load_pixel(8'd1, 8'd0, 16'hFFFF);
    load_pixel(8'd1, 8'd1, 16'hFFFF);
    load_pixel(8'd255, 8'd255, 16'hFFFF);
    load_pixel(8'd255, 8'd254, 16'h0000);
    load_pixel(8'd255, 8'd0, 16'h8001);
    query_pixel(12'd0, 12'd0);
    query_pixel(12'd255, 12'd255);
    query_pixel(12'd255, 12'd254);
    query_pixel(12'd4095, 12'd4095);
    query_pixel(12'd0, 12'd4095);

    // An empty row count reads every neighbor as outside, so all zero.
    drain_and_settle(SETTLE_CYCLES);
    write_config(DIM_W'(0), DIM_W'(511), STEP_W'(0), STEP_W'(32768));
    query_pixel(12'd0, 12'd0);
    query_pixel(12'd4095, 12'd4095);

    // Oversized row count, the largest row step and a zero column step,
    // which splits the weight between column -1 and column 0.
    drain_and_settle(SETTLE_CYCLES);
    write_config(DIM_W'(511), DIM_W'(1), {STEP_W{1'b1}}, STEP_W'(0));
    query_pixel(12'd0, 12'd0);
    query_pixel(12'd0, 12'd5);
    query_pixel(12'd4095, 12'd4095);

    // Tiny image with a 256x row step and the smallest nonzero column step.
    drain_and_settle(SETTLE_CYCLES);
    write_config(DIM_W'(2), DIM_W'(2), STEP_W'(25'h1000000), STEP_W'(1));
    query_pixel(12'd0, 12'd0);
    query_pixel(12'd0, 12'd4095);
    query_pixel(12'd1, 12'd2);

    // Fractional weights on both axes.
    drain_and_settle(SETTLE_CYCLES);
    write_config(DIM_W'(256), DIM_W'(256), STEP_W'(32768), STEP_W'(98304));
    query_pixel(12'd1, 12'd1);
    query_pixel(12'd20, 12'd7);

    // Random phases, each with its own register setting and idling mode.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_and_settle(SETTLE_CYCLES);
      set_idling(idle_mode_e'(p % 4));
      rows  = random_dim();
      cols  = random_dim();
      rstep = random_step(rows);
      cstep = random_step(cols);
      write_config(rows, cols, rstep, cstep);
      row_span = query_span(rows, rstep);
      col_span = query_span(cols, cstep);
      row_top  = (rows == 0 || rows > 256) ? 255 : rows - 1;
      col_top  = (cols == 0 || cols > 256) ? 255 : cols - 1;
      // In the first phase the receiver holds off long enough for the
      // block to fill and push back on the slave side.
      if (p == 0) rx_hold_req <= rx_hold_req + 1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Once the sender stops dead until every result is out.
        if (p == 5 && i == ITEMS_PER_PHASE / 2) drain_and_settle(0);
        if ($urandom_range(9) < 3) begin
          if ($urandom_range(9) < 8)
            load_pixel(SRC_W'($urandom_range(0, row_top)), SRC_W'($urandom_range(0, col_top)),
                       PIX_W'($urandom));
          else
            load_pixel(SRC_W'($urandom), SRC_W'($urandom), PIX_W'($urandom));
        end else begin
          query_pixel(($urandom_range(9) < 7) ? DST_W'($urandom_range(0, row_span))
                                               : DST_W'($urandom),
                      ($urandom_range(9) < 7) ? DST_W'($urandom_range(0, col_span))
                                               : DST_W'($urandom));
        end
      end
    end

    drain_and_settle(SETTLE_CYCLES);

    $display("Sent %0d load beats and %0d query beats under %0d register settings;",
             n_loads, n_queries, n_settings);
    $display("%0d results checked over empty, single-line and oversized images,", checked);
    $display("zero, unit and extreme steps, idling on both sides and a long hold-off.");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
